[hw/rtl/ldf_pkg.sv]
// Shared types, constants and CRC-32 table for the log record deframer.
`timescale 1ns / 1ps

package ldf_pkg;

   localparam int POS_W        = 33;
   localparam int END_W        = 34;
   localparam int BODY_START   = 28;
   localparam int MIN_LAST_POS = 31;
   localparam int RESERVED_POS = 9;
   localparam int FIFO_DEPTH   = 2;
   localparam logic [7:0]  TYPE_LIMIT_RESET = 8'd5;
   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

   typedef enum logic [1:0] {
      KIND_KEY     = 2'd0,
      KIND_VALUE   = 2'd1,
      KIND_VERDICT = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK           = 2'd0,
      ST_SHORT        = 2'd1,
      ST_BAD_TYPE     = 2'd2,
      ST_CRC_MISMATCH = 2'd3
   } status_type;

   // One queued result; header fields are only meaningful for a verdict.
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  body_byte;
      status_type  status;
      logic        check_crc;
      logic [31:0] crc;
      logic [63:0] seq_number;
      logic [7:0]  record_type;
      logic [15:0] key_length;
      logic [31:0] value_length;
      logic [63:0] txn_id;
      logic [31:0] txn_generation;
      logic [31:0] crc_stored;
   } ldf_entry_type;

   typedef logic [31:0] crc_table_type [256];

   function automatic crc_table_type crc_build_table();
      crc_table_type t;
      logic [31:0]   c;
      for (int i = 0; i < 256; i++) begin
         c = 32'(i);
         for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
         end
         t[i] = c;
      end
      return t;
   endfunction

   localparam crc_table_type CRC_TABLE = crc_build_table();

endpackage

[hw/rtl/ldf_fifo.sv]
// Small register queue between the parsing front and the result back end.
`timescale 1ns / 1ps

module ldf_fifo #(
   parameter int DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ldf_pkg::ldf_entry_type wdata,
   output logic                  full,
   input  logic                  pop,
   output ldf_pkg::ldf_entry_type rdata,
   output logic                  empty
);
   import ldf_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   ldf_entry_type    ent_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = ent_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         ent_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

[hw/rtl/ldf_front.sv]
// Byte parser: header capture, running CRC, body and verdict classification.
`timescale 1ns / 1ps

module ldf_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            data_byte,
   input  logic                  last,
   input  logic [7:0]            highest_valid_type,
   output logic                  out_push,
   output ldf_pkg::ldf_entry_type out_entry
);
   import ldf_pkg::*;

   logic [POS_W-1:0] pos_ff,       pos_in;
   logic [31:0]      crc_ff,       crc_in;
   logic [63:0]      seq_ff,       seq_in;
   logic [7:0]       type_ff,      type_in;
   logic [15:0]      key_len_ff,   key_len_in;
   logic [31:0]      value_len_ff, value_len_in;
   logic [63:0]      txn_id_ff,    txn_id_in;
   logic [31:0]      txn_gen_ff,   txn_gen_in;
   logic [31:0]      footer_ff,    footer_in;
   logic             done_ff,      done_in;

   logic [END_W-1:0] p_ext, body_end, key_end, rec_last, foot_off;
   logic             hdr, in_crc, in_footer, bad, verdict, body;
   logic [4:0]       lo;
   logic [7:0]       crc_byte;

   assign p_ext    = END_W'(pos_ff);
   assign hdr      = (pos_ff[POS_W-1:5] == '0);
   assign lo       = pos_ff[4:0];
   // Lengths are complete before the body starts, so the registered copies do.
   assign body_end = END_W'(BODY_START) + END_W'(key_len_ff) + END_W'(value_len_ff);
   assign key_end  = END_W'(BODY_START) + END_W'(key_len_ff);
   assign rec_last = body_end + END_W'(3);
   assign foot_off = p_ext - body_end;
   assign in_crc   = (p_ext < body_end);
   assign in_footer = !in_crc && (foot_off[END_W-1:2] == '0);
   assign bad      = (type_ff > highest_valid_type);
   assign crc_byte = (hdr && lo == 5'(RESERVED_POS)) ? 8'h00 : data_byte;

   always_comb begin
      pos_in       = pos_ff;
      crc_in       = crc_ff;
      seq_in       = seq_ff;
      type_in      = type_ff;
      key_len_in   = key_len_ff;
      value_len_in = value_len_ff;
      txn_id_in    = txn_id_ff;
      txn_gen_in   = txn_gen_ff;
      footer_in    = footer_ff;
      done_in      = done_ff;
      verdict      = 1'b0;
      body         = 1'b0;

      out_entry                = '0;
      out_entry.kind           = KIND_VERDICT;
      out_entry.status         = ST_OK;
      out_entry.body_byte      = data_byte;

      if (accept && !done_ff) begin
         if (hdr) begin
            if (lo < 5'd8) begin
               seq_in[{lo[2:0], 3'b000} +: 8] = data_byte;
            end else if (lo == 5'd8) begin
               type_in = data_byte;
            end else if (lo >= 5'd10 && lo < 5'd12) begin
               key_len_in[{lo[0], 3'b000} +: 8] = data_byte;
            end else if (lo >= 5'd12 && lo < 5'd16) begin
               value_len_in[{lo[1:0], 3'b000} +: 8] = data_byte;
            end else if (lo >= 5'd16 && lo < 5'd24) begin
               txn_id_in[{lo[2:0], 3'b000} +: 8] = data_byte;
            end else if (lo >= 5'd24 && lo < 5'd28) begin
               txn_gen_in[{lo[1:0], 3'b000} +: 8] = data_byte;
            end
         end

         if (in_crc) begin
            crc_in = (crc_ff >> 8) ^ CRC_TABLE[crc_ff[7:0] ^ crc_byte];
         end else if (in_footer) begin
            footer_in[{foot_off[1:0], 3'b000} +: 8] = data_byte;
         end

         priority if (hdr && lo == 5'(MIN_LAST_POS) && bad) begin
            verdict          = 1'b1;
            out_entry.status = ST_BAD_TYPE;
         end else if (p_ext == rec_last) begin
            verdict             = 1'b1;
            out_entry.check_crc = 1'b1;
         end else if (last) begin
            verdict          = 1'b1;
            out_entry.status = ST_SHORT;
         end else if (p_ext >= END_W'(BODY_START) && in_crc && !bad) begin
            body           = 1'b1;
            out_entry.kind = (p_ext < key_end) ? KIND_KEY : KIND_VALUE;
         end else begin
            body = 1'b0;
         end

         done_in = verdict;
         pos_in  = pos_ff + 1'b1;
      end

      out_entry.crc            = crc_in;
      out_entry.seq_number     = seq_in;
      out_entry.record_type    = type_in;
      out_entry.key_length     = key_len_in;
      out_entry.value_length   = value_len_in;
      out_entry.txn_id         = txn_id_in;
      out_entry.txn_generation = txn_gen_in;
      out_entry.crc_stored     = footer_in;

      // Drop all parse state at the end of the buffer.
      if (accept && last) begin
         pos_in       = '0;
         crc_in       = CRC_ONES;
         seq_in       = '0;
         type_in      = '0;
         key_len_in   = '0;
         value_len_in = '0;
         txn_id_in    = '0;
         txn_gen_in   = '0;
         footer_in    = '0;
         done_in      = 1'b0;
      end
   end

   assign out_push = verdict || body;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         crc_ff       <= CRC_ONES;
         seq_ff       <= '0;
         type_ff      <= '0;
         key_len_ff   <= '0;
         value_len_ff <= '0;
         txn_id_ff    <= '0;
         txn_gen_ff   <= '0;
         footer_ff    <= '0;
         done_ff      <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         crc_ff       <= crc_in;
         seq_ff       <= seq_in;
         type_ff      <= type_in;
         key_len_ff   <= key_len_in;
         value_len_ff <= value_len_in;
         txn_id_ff    <= txn_id_in;
         txn_gen_ff   <= txn_gen_in;
         footer_ff    <= footer_in;
         done_ff      <= done_in;
      end
   end

endmodule

[hw/rtl/ldf_back.sv]
// Result formatting: CRC verdict and field masking for the queue head.
`timescale 1ns / 1ps

module ldf_back (
   input  ldf_pkg::ldf_entry_type entry,
   output logic [1:0]            kind,
   output logic [7:0]            body_byte,
   output logic [1:0]            status,
   output logic [63:0]           seq_number,
   output logic [7:0]            record_type,
   output logic [15:0]           key_length,
   output logic [31:0]           value_length,
   output logic [63:0]           txn_id,
   output logic [31:0]           txn_generation,
   output logic [31:0]           crc_stored
);
   import ldf_pkg::*;

   logic       is_verdict;
   status_type st;

   assign is_verdict = (entry.kind == KIND_VERDICT);

   always_comb begin
      st = entry.status;
      if (entry.check_crc) begin
         st = ((entry.crc ^ CRC_ONES) == entry.crc_stored) ? ST_OK : ST_CRC_MISMATCH;
      end
   end

   // Zero the header fields on body items and the byte on verdicts.
   assign kind           = entry.kind;
   assign body_byte      = is_verdict ? 8'h00 : entry.body_byte;
   assign status         = is_verdict ? st : ST_OK;
   assign seq_number     = is_verdict ? entry.seq_number : '0;
   assign record_type    = is_verdict ? entry.record_type : '0;
   assign key_length     = is_verdict ? entry.key_length : '0;
   assign value_length   = is_verdict ? entry.value_length : '0;
   assign txn_id         = is_verdict ? entry.txn_id : '0;
   assign txn_generation = is_verdict ? entry.txn_generation : '0;
   assign crc_stored     = is_verdict ? entry.crc_stored : '0;

endmodule

[hw/rtl/log_record_deframer_crc32.sv]
// Top level: write-ahead-log record deframer with CRC-32 check.
// A result is queued as its causing byte is accepted; rsp_ ports show the queue head.
// Throughput: one byte per cycle unless req_full; the per-byte CRC table update and
// position compare in the parser set the cycle; a FIFO_DEPTH-entry queue absorbs stalls.
// Reset (synchronous, active high): parse state cleared, CRC all ones, queue
// empty, type limit back to 5.
`timescale 1ns / 1ps

module log_record_deframer_crc32 #(
   parameter int FIFO_DEPTH = ldf_pkg::FIFO_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_body_byte,
   output logic [1:0]  rsp_status,
   output logic [63:0] rsp_seq_number,
   output logic [7:0]  rsp_record_type,
   output logic [15:0] rsp_key_length,
   output logic [31:0] rsp_value_length,
   output logic [63:0] rsp_txn_id,
   output logic [31:0] rsp_txn_generation,
   output logic [31:0] rsp_crc_stored,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);
   import ldf_pkg::*;

   logic [7:0]    type_limit_ff;
   logic          accept, pop_fire, front_push;
   ldf_entry_type front_entry, head_entry;

   assign accept   = req_push && !req_full;
   assign pop_fire = rsp_pop && !rsp_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         type_limit_ff <= TYPE_LIMIT_RESET;
      end else if (csr_wr_en) begin
         type_limit_ff <= csr_wr_data;
      end
   end

   ldf_front u_front (
      .clock              (clock),
      .reset              (reset),
      .accept             (accept),
      .data_byte          (req_data_byte),
      .last               (req_last),
      .highest_valid_type (type_limit_ff),
      .out_push           (front_push),
      .out_entry          (front_entry)
   );

   ldf_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (front_push),
      .wdata (front_entry),
      .full  (req_full),
      .pop   (rsp_pop),
      .rdata (head_entry),
      .empty (rsp_empty)
   );

   ldf_back u_back (
      .entry          (head_entry),
      .kind           (rsp_kind),
      .body_byte      (rsp_body_byte),
      .status         (rsp_status),
      .seq_number     (rsp_seq_number),
      .record_type    (rsp_record_type),
      .key_length     (rsp_key_length),
      .value_length   (rsp_value_length),
      .txn_id         (rsp_txn_id),
      .txn_generation (rsp_txn_generation),
      .crc_stored     (rsp_crc_stored)
   );

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      front_push |-> !req_full)
      else $error("parser pushed a result into a full queue");

   a_push_shows: assert property (@(posedge clock) disable iff (reset)
      (front_push && !pop_fire) |=> !rsp_empty)
      else $error("pushed result did not appear at the queue head");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      (rsp_empty && !front_push) |=> rsp_empty)
      else $error("result appeared without a push");

endmodule

[dv/ldf_tb_pkg.sv]
// Verification types and CRC helper shared by the deframer checker and testbench.
`timescale 1ns / 1ps

package ldf_tb_pkg;

   import ldf_pkg::*;

   // One result as seen on the rsp_ ports.
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  body_byte;
      status_type  status;
      logic [63:0] seq_number;
      logic [7:0]  record_type;
      logic [15:0] key_length;
      logic [31:0] value_length;
      logic [63:0] txn_id;
      logic [31:0] txn_generation;
      logic [31:0] crc_stored;
   } deframe_result_type;

   // Advance a reflected CRC-32 by one byte, bit-serial.
   function automatic logic [31:0] crc32_next(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'h0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

[dv/ldf_deframe_checker.sv]
// Checker that predicts deframer results from accepted bytes and compares popped results.
`timescale 1ns / 1ps

module ldf_deframe_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  logic [1:0]  rsp_kind,
   input  logic [7:0]  rsp_body_byte,
   input  logic [1:0]  rsp_status,
   input  logic [63:0] rsp_seq_number,
   input  logic [7:0]  rsp_record_type,
   input  logic [15:0] rsp_key_length,
   input  logic [31:0] rsp_value_length,
   input  logic [63:0] rsp_txn_id,
   input  logic [31:0] rsp_txn_generation,
   input  logic [31:0] rsp_crc_stored,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   output int          mismatch_count,
   output int          results_pending,
   output int          body_count,
   output int          ok_count,
   output int          short_count,
   output int          bad_type_count,
   output int          crc_err_count
);

   import ldf_pkg::*;
   import ldf_tb_pkg::*;

   logic [POS_W-1:0] rec_pos;
   logic [31:0]      crc_acc;
   logic [63:0]      seq_acc;
   logic [7:0]       type_acc;
   logic [15:0]      klen_acc;
   logic [31:0]      vlen_acc;
   logic [63:0]      txn_acc;
   logic [31:0]      gen_acc;
   logic [31:0]      footer_acc;
   logic             finished;
   logic [7:0]       type_limit;

   deframe_result_type predicted_results [$];

   function automatic string describe(input deframe_result_type r);
      return $sformatf({"kind %0d byte %h status %0d seq %h type %h klen %h vlen %h ",
                        "txn %h gen %h crc %h"},
                       r.kind, r.body_byte, r.status, r.seq_number, r.record_type,
                       r.key_length, r.value_length, r.txn_id, r.txn_generation,
                       r.crc_stored);
   endfunction

   function automatic deframe_result_type verdict_of(input status_type st);
      deframe_result_type r;
      r                = '0;
      r.kind           = KIND_VERDICT;
      r.status         = st;
      r.seq_number     = seq_acc;
      r.record_type    = type_acc;
      r.key_length     = klen_acc;
      r.value_length   = vlen_acc;
      r.txn_id         = txn_acc;
      r.txn_generation = gen_acc;
      r.crc_stored     = footer_acc;
      return r;
   endfunction

   // Append one predicted result behind those already waiting.
   task automatic add_prediction(input deframe_result_type r);
      predicted_results = {predicted_results, r};
   endtask

   task automatic clear_record();
      rec_pos    = '0;
      crc_acc    = CRC_ONES;
      seq_acc    = '0;
      type_acc   = '0;
      klen_acc   = '0;
      vlen_acc   = '0;
      txn_acc    = '0;
      gen_acc    = '0;
      footer_acc = '0;
      finished   = 1'b0;
   endtask

   // Work out what one accepted byte produces and queue it.
   task automatic deframe_byte(input logic [7:0] b, input logic lst);
      logic [END_W-1:0] p;
      logic [END_W-1:0] body_end;
      logic [END_W-1:0] rec_end;
      logic [END_W-1:0] off;
      logic             bad;
      deframe_result_type r;
      if (!finished) begin
         p = END_W'(rec_pos);
         if (p < 8)
            seq_acc = seq_acc | ({56'h0, b} << (8 * p));
         else if (p == 8)
            type_acc = b;
         else if (p >= 10 && p < 12)
            klen_acc = klen_acc | ({8'h0, b} << (8 * (p - 10)));
         else if (p >= 12 && p < 16)
            vlen_acc = vlen_acc | ({24'h0, b} << (8 * (p - 12)));
         else if (p >= 16 && p < 24)
            txn_acc = txn_acc | ({56'h0, b} << (8 * (p - 16)));
         else if (p >= 24 && p < BODY_START)
            gen_acc = gen_acc | ({24'h0, b} << (8 * (p - 24)));

         body_end = END_W'(BODY_START) + END_W'(klen_acc) + END_W'(vlen_acc);
         rec_end  = body_end + END_W'(4);
         off      = p - body_end;

         // Reserved byte enters the CRC as zero.
         if (p < body_end)
            crc_acc = crc32_next(crc_acc, (p == RESERVED_POS) ? 8'h00 : b);
         else if (off < 4)
            footer_acc = footer_acc | ({24'h0, b} << (8 * off[1:0]));

         bad = type_acc > type_limit;

         if (p == MIN_LAST_POS && bad) begin
            add_prediction(verdict_of(ST_BAD_TYPE));
            finished = 1'b1;
         end else if (p == rec_end - END_W'(1)) begin
            add_prediction(verdict_of(((crc_acc ^ CRC_ONES) == footer_acc) ?
                                      ST_OK : ST_CRC_MISMATCH));
            finished = 1'b1;
         end else if (lst) begin
            add_prediction(verdict_of(ST_SHORT));
            finished = 1'b1;
         end else if (p >= BODY_START && p < body_end && !bad) begin
            r           = '0;
            r.kind      = (p < END_W'(BODY_START) + END_W'(klen_acc)) ? KIND_KEY : KIND_VALUE;
            r.body_byte = b;
            add_prediction(r);
         end
         rec_pos = rec_pos + 1'b1;
      end
      if (lst)
         clear_record();
   endtask

   always @(posedge clock) begin : watch
      deframe_result_type seen;
      deframe_result_type want;
      if (reset) begin
         clear_record();
         type_limit = TYPE_LIMIT_RESET;
         predicted_results.delete();
      end else begin
         if (csr_wr_en)
            type_limit = csr_wr_data;

         if (rsp_pop && !rsp_empty) begin
            seen.kind           = kind_type'(rsp_kind);
            seen.body_byte      = rsp_body_byte;
            seen.status         = status_type'(rsp_status);
            seen.seq_number     = rsp_seq_number;
            seen.record_type    = rsp_record_type;
            seen.key_length     = rsp_key_length;
            seen.value_length   = rsp_value_length;
            seen.txn_id         = rsp_txn_id;
            seen.txn_generation = rsp_txn_generation;
            seen.crc_stored     = rsp_crc_stored;
            if (predicted_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("[%0t] unexpected result, nothing predicted: %s",
                           $time, describe(seen));
            end else begin
               want = predicted_results.pop_front();
               if (seen !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("[%0t] result mismatch", $time);
                     $display("   expected %s", describe(want));
                     $display("   actual   %s", describe(seen));
                  end
               end
               if (want.kind != KIND_VERDICT)
                  body_count++;
               else begin
                  unique case (want.status)
                     ST_OK:           ok_count++;
                     ST_SHORT:        short_count++;
                     ST_BAD_TYPE:     bad_type_count++;
                     ST_CRC_MISMATCH: crc_err_count++;
                  endcase
               end
            end
         end

         if (req_push && !req_full)
            deframe_byte(req_data_byte, req_last);
      end
      results_pending = predicted_results.size();
   end

endmodule

[dv/log_record_deframer_crc32_tb.sv]
// Testbench top: drives log records into the deframer and reports the checker's verdict.
`timescale 1ns / 1ps

module log_record_deframer_crc32_tb;

   import ldf_pkg::*;
   import ldf_tb_pkg::*;

   localparam int RANDOM_BYTES = 1450;
   localparam int NO_CUT       = 1 << 30;
   localparam int STALL_LIMIT  = 4000;
   localparam int SETTLE       = 8;

   logic        clock;
   logic        reset         = 1'b1;
   logic        req_push      = 1'b0;
   logic        req_full;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_last      = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop       = 1'b0;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_body_byte;
   logic [1:0]  rsp_status;
   logic [63:0] rsp_seq_number;
   logic [7:0]  rsp_record_type;
   logic [15:0] rsp_key_length;
   logic [31:0] rsp_value_length;
   logic [63:0] rsp_txn_id;
   logic [31:0] rsp_txn_generation;
   logic [31:0] rsp_crc_stored;
   logic        csr_wr_en     = 1'b0;
   logic [7:0]  csr_wr_data   = 8'h00;

   int mismatch_count;
   int results_pending;
   int body_count;
   int ok_count;
   int short_count;
   int bad_type_count;
   int crc_err_count;

   int         bytes_sent   = 0;
   int         buffers_sent = 0;
   int         limit_writes = 0;
   bit         calm         = 1'b0;
   logic [7:0] type_limit   = TYPE_LIMIT_RESET;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   log_record_deframer_crc32 i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_data_byte      (req_data_byte),
      .req_last           (req_last),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_kind           (rsp_kind),
      .rsp_body_byte      (rsp_body_byte),
      .rsp_status         (rsp_status),
      .rsp_seq_number     (rsp_seq_number),
      .rsp_record_type    (rsp_record_type),
      .rsp_key_length     (rsp_key_length),
      .rsp_value_length   (rsp_value_length),
      .rsp_txn_id         (rsp_txn_id),
      .rsp_txn_generation (rsp_txn_generation),
      .rsp_crc_stored     (rsp_crc_stored),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   ldf_deframe_checker i_checker (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_data_byte      (req_data_byte),
      .req_last           (req_last),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_kind           (rsp_kind),
      .rsp_body_byte      (rsp_body_byte),
      .rsp_status         (rsp_status),
      .rsp_seq_number     (rsp_seq_number),
      .rsp_record_type    (rsp_record_type),
      .rsp_key_length     (rsp_key_length),
      .rsp_value_length   (rsp_value_length),
      .rsp_txn_id         (rsp_txn_id),
      .rsp_txn_generation (rsp_txn_generation),
      .rsp_crc_stored     (rsp_crc_stored),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .mismatch_count     (mismatch_count),
      .results_pending    (results_pending),
      .body_count         (body_count),
      .ok_count           (ok_count),
      .short_count        (short_count),
      .bad_type_count     (bad_type_count),
      .crc_err_count      (crc_err_count)
   );

   // Stall the result side now and then, never while calm.
   always @(posedge clock) begin
      if (reset)
         rsp_pop <= 1'b0;
      else
         rsp_pop <= calm || ($urandom_range(99) >= 19);
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic push_byte(input logic [7:0] b, input logic lst);
      while (!calm && $urandom_range(99) < 19) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push      <= 1'b1;
      req_data_byte <= b;
      req_last      <= lst;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_buffer(ref logic [7:0] buf_bytes [$]);
      for (int i = 0; i < buf_bytes.size(); i++)
         push_byte(buf_bytes[i], i == buf_bytes.size() - 1);
      buffers_sent++;
   endtask

   // Build one record, optionally with a bad footer, trailing bytes or a cut, and send it.
   task automatic send_record(input logic [63:0] seq, input logic [7:0] rtype,
                              input logic [15:0] klen, input logic [31:0] vlen,
                              input logic [63:0] txid, input logic [31:0] gen,
                              input bit corrupt, input int extra, input int cut);
      logic [7:0]      rec [$];
      logic [223:0]    hdr;
      logic [7:0]      rsvd;
      logic [7:0]      b;
      logic [31:0]     crc;
      logic [31:0]     footer;
      longint unsigned body_len;
      rsvd = 8'($urandom);
      hdr  = {gen, txid, vlen, klen, rsvd, rtype, seq};
      crc  = CRC_ONES;
      for (int i = 0; i < BODY_START; i++) begin
         rec = {rec, hdr[8 * i +: 8]};
         crc = crc32_next(crc, (i == RESERVED_POS) ? 8'h00 : hdr[8 * i +: 8]);
      end
      body_len = longint'(klen) + longint'(vlen);
      for (longint unsigned i = 0; i < body_len && rec.size() < cut; i++) begin
         b   = 8'($urandom);
         rec = {rec, b};
         crc = crc32_next(crc, b);
      end
      footer = ~crc;
      if (corrupt)
         footer = footer ^ (32'h1 << $urandom_range(31));
      for (int i = 0; i < 4; i++)
         rec = {rec, footer[8 * i +: 8]};
      for (int i = 0; i < extra; i++)
         rec = {rec, 8'($urandom)};
      while (rec.size() > cut)
         void'(rec.pop_back());
      send_buffer(rec);
   endtask

   task automatic send_noise(input int len);
      logic [7:0] rec [$];
      for (int i = 0; i < len; i++)
         rec = {rec, 8'($urandom)};
      send_buffer(rec);
   endtask

   // Drain every pending result, let the pipeline settle, then write the type limit.
   task automatic set_type_limit(input logic [7:0] v);
      req_push <= 1'b0;
      while (results_pending != 0)
         @(negedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      type_limit = v;
      limit_writes++;
   endtask

   initial begin
      logic [15:0] klen;
      logic [31:0] vlen;
      logic [7:0]  good_t;
      logic [7:0]  bad_t;
      logic [7:0]  limits [4];
      int          pick;
      int          full_len;
      int          phase_end;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: one-byte buffer, minimal ok and bad-type records, CRC error,
      // extreme header values, key-only and value-only bodies, cuts in header, body and footer.
      send_record(rand64(), 8'd1, 16'd0, 32'd0, rand64(), $urandom, 1'b0, 0, 1);
      send_record(64'h0, TYPE_LIMIT_RESET, 16'd0, 32'd0, 64'h0, 32'h0, 1'b0, 0, NO_CUT);
      send_record(rand64(), TYPE_LIMIT_RESET + 8'd1, 16'd0, 32'd0, rand64(), $urandom,
                  1'b0, 0, NO_CUT);
      send_record(rand64(), 8'hFF, 16'd2, 32'd3, rand64(), $urandom, 1'b0, 3, NO_CUT);
      send_record(rand64(), 8'd0, 16'd3, 32'd4, rand64(), $urandom, 1'b1, 2, NO_CUT);
      send_record('1, 8'd3, 16'd4, 32'd0, '1, '1, 1'b0, 0, NO_CUT);
      send_record(rand64(), 8'd4, 16'd0, 32'd5, rand64(), $urandom, 1'b0, 1, NO_CUT);
      send_record(rand64(), 8'd2, 16'd1, 32'd1, rand64(), $urandom, 1'b0, 0, 31);
      send_record(rand64(), 8'd2, 16'd1, 32'd2, rand64(), $urandom, 1'b0, 0, 33);
      send_record(rand64(), 8'd1, 16'hFFFF, 32'hFFFF_FFFF, rand64(), $urandom, 1'b0, 0, 45);
      send_record(rand64(), 8'd200, 16'd2, 32'd2, rand64(), $urandom, 1'b0, 0, 20);

      limits[0] = 8'hFF;
      limits[1] = 8'h00;
      limits[2] = 8'($urandom_range(254, 1));
      limits[3] = TYPE_LIMIT_RESET;
      for (int ph = 0; ph < 4; ph++) begin
         set_type_limit(limits[ph]);
         phase_end = bytes_sent + RANDOM_BYTES / 4;
         while (bytes_sent < phase_end) begin
            // Hold both sides busy through the tail of the third phase.
            calm   = (ph == 2) && (phase_end - bytes_sent < RANDOM_BYTES / 8);
            klen   = 16'(($urandom_range(7) == 0) ? $urandom_range(40) : $urandom_range(6));
            vlen   = ($urandom_range(7) == 0) ? $urandom_range(60) : $urandom_range(8);
            good_t = 8'($urandom_range(type_limit, 0));
            bad_t  = (type_limit == 8'hFF) ? good_t :
                     8'($urandom_range(255, type_limit + 1));
            pick   = $urandom_range(99);
            if (pick < 55)
               send_record(rand64(), good_t, klen, vlen, rand64(), $urandom,
                           $urandom_range(5) == 0,
                           ($urandom_range(3) == 0) ? $urandom_range(6, 1) : 0, NO_CUT);
            else if (pick < 68)
               send_record(rand64(), bad_t, klen, vlen, rand64(), $urandom, 1'b0,
                           $urandom_range(4), NO_CUT);
            else if (pick < 72)
               send_record(rand64(), good_t, 16'($urandom), $urandom, rand64(), $urandom,
                           1'b0, 0, $urandom_range(80, 1));
            else if (pick < 88) begin
               full_len = 32 + klen + vlen;
               send_record(rand64(), ($urandom_range(3) == 0) ? bad_t : good_t, klen, vlen,
                           rand64(), $urandom, 1'b0, 0, $urandom_range(full_len - 1, 1));
            end else
               send_noise($urandom_range(48, 1));
         end
      end
      calm = 1'b0;

      req_push <= 1'b0;
      while (results_pending != 0)
         @(negedge clock);
      repeat (SETTLE) @(posedge clock);

      $display("Sent %0d bytes in %0d buffers under %0d type-limit writes; %0d body bytes checked",
               bytes_sent, buffers_sent, limit_writes, body_count);
      $display("Verdicts checked: %0d ok, %0d too short, %0d bad type, %0d CRC mismatch",
               ok_count, short_count, bad_type_count, crc_err_count);
      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // End the run if neither side moves an item for too long.
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty))
            quiet = 0;
         else
            quiet++;
      end
      $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
      $display("Verification failed");
      $finish;
   end

endmodule

[files.f]
hw/rtl/ldf_pkg.sv
hw/rtl/ldf_fifo.sv
hw/rtl/ldf_front.sv
hw/rtl/ldf_back.sv
hw/rtl/log_record_deframer_crc32.sv
dv/ldf_tb_pkg.sv
dv/ldf_deframe_checker.sv
dv/log_record_deframer_crc32_tb.sv
